[src/b64d_pkg.sv]
package b64d_pkg;

  // widths
  localparam int COUNT_BITS  = 12;
  localparam int LIMIT_W     = 12;
  localparam int CMP_W       = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(384);

  // result kinds
  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_DONE     = 2'd1;
  localparam logic [1:0] KIND_BAD_CHAR = 2'd2;
  localparam logic [1:0] KIND_OVERFLOW = 2'd3;

  // character classes, skip never enters the queue
  localparam logic [1:0] CLS_SEXTET = 2'd0;
  localparam logic [1:0] CLS_BAD    = 2'd1;
  localparam logic [1:0] CLS_END    = 2'd2;
  localparam logic [1:0] CLS_SKIP   = 2'd3;

  typedef struct packed {
    logic       is_end;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [11:0] byte_count;
  } out_item_t;

  typedef struct packed {
    logic [1:0] cls;
    logic [5:0] sextet;
  } q_entry_t;

  // map one input item to its class and 6-bit value
  function automatic q_entry_t classify(input in_item_t item);
    q_entry_t   e;
    logic [7:0] ch;
    logic [7:0] d;
    ch       = item.char_code;
    d        = 8'd0;
    e.cls    = CLS_BAD;
    e.sextet = 6'd0;
    if (item.is_end) begin
      e.cls = CLS_END;
    end else if (ch >= 8'h41 && ch <= 8'h5A) begin
      d     = ch - 8'h41;
      e.cls = CLS_SEXTET;
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      d     = ch - 8'h61 + 8'd26;
      e.cls = CLS_SEXTET;
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      d     = ch - 8'h30 + 8'd52;
      e.cls = CLS_SEXTET;
    end else if (ch == 8'h2D || ch == 8'h2B) begin
      d     = 8'd62;
      e.cls = CLS_SEXTET;
    end else if (ch == 8'h5F || ch == 8'h2F) begin
      d     = 8'd63;
      e.cls = CLS_SEXTET;
    end else if (ch == 8'h3D || ch == 8'h0D || ch == 8'h0A || ch == 8'h20 ||
                 ch == 8'h09) begin
      e.cls = CLS_SKIP;
    end
    e.sextet = d[5:0];
    return e;
  endfunction

endpackage

[src/base64url_stream_decoder.sv]
// channel  direction  payload              transfer when
// in       input      in_item_t            in_valid & in_ready
// out      output     out_item_t           out_valid & out_ready
// cfg      input      output_limit 12 bit  cfg_valid & cfg_ready (always ready)
//
// one character per cycle sustained unless the output stalls; a taken character
// goes into the queue, then its result into the output register; with the output
// slot free the back end updates buffer, fill and count for one entry per cycle
// synchronous reset clears queue, decode state and output valid, limit to 384
// a stalled output holds the back end; the two-entry queue then fills and
// in_ready drops, skipped characters never occupy the queue
module base64url_stream_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  b64d_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output b64d_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [11:0]         cfg_data
);

  logic               q_ready;
  logic               q_valid;
  logic               push;
  logic               pop;
  b64d_pkg::q_entry_t push_entry;
  b64d_pkg::q_entry_t q_head;

  // limit register is always writable
  assign cfg_ready = 1'b1;

  // classify and drop skipped characters
  b64d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_ready    (q_ready),
    .push       (push),
    .push_entry (push_entry)
  );

  // decouple front from back
  b64d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .pop        (pop)
  );

  // bit packing, counting and results
  b64d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[src/b64d_front.sv]
module b64d_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  b64d_pkg::in_item_t in_data,
  input  logic               q_ready,
  output logic               push,
  output b64d_pkg::q_entry_t push_entry
);

  b64d_pkg::q_entry_t cls_entry;

  // classify the offered character
  assign cls_entry = b64d_pkg::classify(in_data);

  // skipped characters are taken and dropped here
  assign in_ready   = q_ready;
  assign push       = in_valid && q_ready && (cls_entry.cls != b64d_pkg::CLS_SKIP);
  assign push_entry = cls_entry;

`ifndef ASSERT_OFF
  a_skip_not_pushed: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_data.is_end && in_data.char_code == 8'h3D) |-> !push)
    else $error("padding character pushed into queue");
`endif

endmodule

[src/b64d_queue.sv]
module b64d_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  b64d_pkg::q_entry_t push_entry,
  output logic               q_ready,
  output logic               q_valid,
  output b64d_pkg::q_entry_t q_head,
  input  logic               pop
);

  b64d_pkg::q_entry_t                 entries [b64d_pkg::QUEUE_DEPTH];
  logic [b64d_pkg::QPTR_W-1:0]        wr_ptr;
  logic [b64d_pkg::QPTR_W-1:0]        rd_ptr;
  logic [b64d_pkg::QCNT_W-1:0]        count;

  assign q_ready = (count != b64d_pkg::QCNT_W'(b64d_pkg::QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_head  = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == b64d_pkg::QPTR_W'(b64d_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == b64d_pkg::QPTR_W'(b64d_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    push |-> q_ready)
    else $error("push into full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from empty queue");
`endif

endmodule

[src/b64d_back.sv]
module b64d_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [11:0]         cfg_data,
  input  logic                q_valid,
  input  b64d_pkg::q_entry_t  q_head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output b64d_pkg::out_item_t out_data
);

  logic [b64d_pkg::LIMIT_W-1:0]    output_limit;
  logic [5:0]                      bit_buffer;
  logic [5:0]                      bit_buffer_next;
  logic [2:0]                      bit_fill;
  logic [2:0]                      bit_fill_next;
  logic [b64d_pkg::COUNT_BITS-1:0] out_count;
  logic [b64d_pkg::COUNT_BITS-1:0] out_count_next;
  logic                            failed;
  logic                            failed_next;
  logic                            res_valid;
  b64d_pkg::out_item_t             res;
  logic [11:0]                     acc;
  logic [b64d_pkg::CMP_W-1:0]      count_ext;
  logic                            at_limit;

  // take the head item whenever the output slot is free
  assign pop       = q_valid && (!out_valid || out_ready);
  assign acc       = {bit_buffer, q_head.sextet};
  assign count_ext = b64d_pkg::CMP_W'(out_count);
  assign at_limit  = count_ext >= b64d_pkg::CMP_W'(output_limit);

  // per item state update and result
  always_comb begin
    bit_buffer_next = bit_buffer;
    bit_fill_next   = bit_fill;
    out_count_next  = out_count;
    failed_next     = failed;
    res_valid       = 1'b0;
    res             = '0;
    unique case (q_head.cls)
      b64d_pkg::CLS_END: begin
        bit_buffer_next = '0;
        bit_fill_next   = '0;
        out_count_next  = '0;
        failed_next     = 1'b0;
        res_valid       = !failed;
        res.kind        = b64d_pkg::KIND_DONE;
        res.byte_count  = count_ext[b64d_pkg::LIMIT_W-1:0];
      end
      b64d_pkg::CLS_BAD: begin
        if (!failed) begin
          failed_next = 1'b1;
          res_valid   = 1'b1;
          res.kind    = b64d_pkg::KIND_BAD_CHAR;
        end
      end
      b64d_pkg::CLS_SEXTET: begin
        if (!failed) begin
          if (bit_fill == 3'd0) begin
            bit_buffer_next = q_head.sextet;
            bit_fill_next   = 3'd6;
          end else if (at_limit) begin
            failed_next = 1'b1;
            res_valid   = 1'b1;
            res.kind    = b64d_pkg::KIND_OVERFLOW;
          end else begin
            out_count_next = out_count + 1'b1;
            bit_fill_next  = bit_fill - 3'd2;
            res_valid      = 1'b1;
            res.kind       = b64d_pkg::KIND_BYTE;
            unique case (bit_fill)
              3'd2: begin
                res.data_byte   = acc[7:0];
                bit_buffer_next = '0;
              end
              3'd4: begin
                res.data_byte   = acc[9:2];
                bit_buffer_next = {4'd0, acc[1:0]};
              end
              default: begin
                res.data_byte   = acc[11:4];
                bit_buffer_next = {2'd0, acc[3:0]};
              end
            endcase
          end
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // decode state and limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit <= b64d_pkg::LIMIT_RESET;
      bit_buffer   <= '0;
      bit_fill     <= '0;
      out_count    <= '0;
      failed       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        output_limit <= cfg_data;
      end
      if (pop) begin
        bit_buffer <= bit_buffer_next;
        bit_fill   <= bit_fill_next;
        out_count  <= out_count_next;
        failed     <= failed_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= res;
    end
  end

`ifndef ASSERT_OFF
  a_fill_even: assert property (@(posedge clk) disable iff (rst)
    (bit_fill == 3'd0 || bit_fill == 3'd2 || bit_fill == 3'd4 || bit_fill == 3'd6))
    else $error("bit fill left an odd or oversized count");
  a_byte_counts: assert property (@(posedge clk) disable iff (rst)
    (pop && res_valid && res.kind == b64d_pkg::KIND_BYTE) |=>
    out_count == $past(out_count) + 1'b1)
    else $error("decoded byte without count increment");
  a_error_sets_failed: assert property (@(posedge clk) disable iff (rst)
    (pop && res_valid && (res.kind == b64d_pkg::KIND_BAD_CHAR ||
                          res.kind == b64d_pkg::KIND_OVERFLOW)) |=> failed)
    else $error("error reported without entering failed state");
  a_byte_field_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.kind != b64d_pkg::KIND_BYTE) |-> out_data.data_byte == 8'd0)
    else $error("data byte set on a non-byte result");
`endif

endmodule

[tb/base64url_stream_decoder_tb.sv]
module base64url_stream_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CYCLE_LIMIT = 400000;
  localparam int         PHASE_ITEMS = 140;
  localparam logic [6:0] NO_SEXTET   = 7'd64;
  localparam logic [7:0] CH_PAD      = 8'h3D;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_PATTERN,
    READY_SPARSE,
    READY_COIN
  } ready_mode_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  b64d_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  b64d_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [11:0]         cfg_data  = '0;

  base64url_stream_decoder uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // characters waiting to go out and results still owed by the block
  b64d_pkg::in_item_t  pending_chars[$];
  b64d_pkg::out_item_t expected_results[$];
  int          items_queued = 0;
  int          mismatches   = 0;
  int          cycle_count  = 0;
  bit          in_taken     = 1'b0;
  bit          cfg_taken    = 1'b0;

  // decoder state as the testbench tracks it
  logic [11:0] byte_limit  = b64d_pkg::LIMIT_RESET;
  logic [11:0] pend_bits   = '0;
  logic [2:0]  pend_fill   = '0;
  logic [11:0] bytes_out   = '0;
  logic        text_failed = 1'b0;

  // alphabet lookup, both url-safe and standard symbols
  function automatic logic [6:0] sextet_value(input logic [7:0] ch);
    if (ch >= "A" && ch <= "Z") return 7'(ch - "A");
    if (ch >= "a" && ch <= "z") return 7'(ch - "a" + 8'd26);
    if (ch >= "0" && ch <= "9") return 7'(ch - "0" + 8'd52);
    if (ch == "-" || ch == "+") return 7'd62;
    if (ch == "_" || ch == "/") return 7'd63;
    return NO_SEXTET;
  endfunction

  function automatic bit is_blank(input logic [7:0] ch);
    return ch == CH_PAD || ch == CH_CR || ch == CH_LF || ch == CH_SPACE || ch == CH_TAB;
  endfunction

  // expected result for one accepted character or end marker
  function automatic void decode_char(input b64d_pkg::in_item_t item, output logic emits,
                                      output b64d_pkg::out_item_t res);
    logic [6:0]  v;
    logic [11:0] acc;
    logic [3:0]  fill;
    emits = 1'b0;
    res   = '0;
    if (item.is_end) begin
      if (!text_failed) begin
        emits          = 1'b1;
        res.kind       = b64d_pkg::KIND_DONE;
        res.byte_count = bytes_out;
      end
      pend_bits   = '0;
      pend_fill   = '0;
      bytes_out   = '0;
      text_failed = 1'b0;
      return;
    end
    if (text_failed || is_blank(item.char_code)) return;
    v = sextet_value(item.char_code);
    if (v == NO_SEXTET) begin
      text_failed = 1'b1;
      emits       = 1'b1;
      res.kind    = b64d_pkg::KIND_BAD_CHAR;
      return;
    end
    acc  = ((pend_bits & ((12'd1 << pend_fill) - 12'd1)) << 6) | 12'(v[5:0]);
    fill = 4'(pend_fill) + 4'd6;
    if (fill < 4'd8) begin
      pend_bits = acc;
      pend_fill = 3'(fill);
      return;
    end
    fill  = fill - 4'd8;
    emits = 1'b1;
    if (bytes_out >= byte_limit) begin
      text_failed = 1'b1;
      res.kind    = b64d_pkg::KIND_OVERFLOW;
      return;
    end
    bytes_out     = bytes_out + 12'd1;
    res.kind      = b64d_pkg::KIND_BYTE;
    res.data_byte = 8'(acc >> fill);
    pend_bits     = acc & ((12'd1 << fill) - 12'd1);
    pend_fill     = 3'(fill);
  endfunction

  // character for a 6-bit value, alt picks the standard symbols
  function automatic logic [7:0] sextet_char(input logic [5:0] v, input bit alt);
    if (v < 6'd26) return 8'h41 + 8'(v);
    if (v < 6'd52) return 8'h61 + 8'(v - 6'd26);
    if (v < 6'd62) return 8'h30 + 8'(v - 6'd52);
    if (v == 6'd62) return alt ? "+" : "-";
    return alt ? "/" : "_";
  endfunction

  function automatic logic [7:0] invalid_char();
    logic [7:0] ch;
    do begin
      ch = 8'($urandom_range(0, 255));
    end while (sextet_value(ch) != NO_SEXTET || is_blank(ch));
    return ch;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 4))
      0:       return CH_PAD;
      1:       return CH_CR;
      2:       return CH_LF;
      3:       return CH_SPACE;
      default: return CH_TAB;
    endcase
  endfunction

  task automatic push_char(input logic [7:0] ch);
    b64d_pkg::in_item_t item;
    item.is_end    = 1'b0;
    item.char_code = ch;
    pending_chars.push_back(item);
    items_queued++;
  endtask

  // end marker carries a random, ignored character field
  task automatic push_end();
    b64d_pkg::in_item_t item;
    item.is_end    = 1'b1;
    item.char_code = 8'($urandom);
    pending_chars.push_back(item);
    items_queued++;
  endtask

  task automatic push_string(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  // one text: mostly well formed, some with a bad character, a few pure noise
  task automatic queue_random_text(input int min_len, input int max_len,
                                   input bit allow_errors);
    int pick;
    int n;
    int bad_at;
    pick = allow_errors ? $urandom_range(0, 99) : 99;
    if (pick < 6) begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) push_char(8'($urandom_range(0, 255)));
    end else begin
      n      = $urandom_range(min_len, max_len);
      bad_at = (pick < 18) ? $urandom_range(0, n) : -1;
      for (int i = 0; i <= n; i++) begin
        if (i == bad_at) push_char(invalid_char());
        if (i == n) break;
        if ($urandom_range(0, 9) == 0) push_char(blank_char());
        push_char(sextet_char(6'($urandom), 1'($urandom)));
      end
      if ($urandom_range(0, 3) == 0) push_char(CH_PAD);
    end
    push_end();
  endtask

  // sender holds off until every result is in, then lets the block settle
  task automatic wait_idle();
    do @(negedge clk);
    while (!(pending_chars.size() == 0 && (!in_valid || in_taken) &&
             expected_results.size() == 0));
    repeat (6) @(negedge clk);
  endtask

  task automatic write_limit(input logic [11:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(negedge clk);
    while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  // input driver, bursts with random gaps
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_chars.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_chars.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall pattern, mode re-picked at random from ready_tick
  ready_mode_t ready_mode = READY_ALWAYS;
  logic [31:0] ready_bits = '1;
  int          ready_tick = 0;

  always @(negedge clk) begin
    ready_tick <= ready_tick + 1;
    if (ready_tick % 256 == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
      ready_bits <= $urandom;
    end
    case (ready_mode)
      READY_ALWAYS:  out_ready <= 1'b1;
      READY_PATTERN: out_ready <= ready_bits[ready_tick % 32];
      READY_SPARSE:  out_ready <= ($urandom_range(0, 7) == 0);
      default:       out_ready <= 1'($urandom);
    endcase
  end

  // transfer monitor: predicts on accepted input, checks accepted output
  always @(posedge clk) begin : monitor
    logic                emits;
    b64d_pkg::out_item_t want;
    b64d_pkg::out_item_t predicted;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL base64url_stream_decoder");
      $finish;
    end else if (rst) begin
      in_taken  = 1'b0;
      cfg_taken = 1'b0;
    end else begin
      cfg_taken = cfg_valid && cfg_ready;
      if (cfg_taken) byte_limit = cfg_data;
      in_taken = in_valid && in_ready;
      if (in_taken) begin
        decode_char(in_data, emits, predicted);
        if (emits) expected_results.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: expected no result, got kind %0d data %02h count %0d",
                   $time, out_data.kind, out_data.data_byte, out_data.byte_count);
        end else begin
          want = expected_results.pop_front();
          if (out_data.kind !== want.kind || out_data.data_byte !== want.data_byte ||
              out_data.byte_count !== want.byte_count) begin
            mismatches++;
            $display("%0t: expected kind %0d data %02h count %0d,", $time,
                     want.kind, want.data_byte, want.byte_count,
                     " got kind %0d data %02h count %0d",
                     out_data.kind, out_data.data_byte, out_data.byte_count);
          end
        end
      end
    end
  end

  // stimulus phases
  initial begin
    logic [11:0] phase_limits[$];
    int          start;
    phase_limits = '{12'd4095, 12'd1, 12'd384, 12'd0, 12'd7, 12'd2,
                     12'($urandom_range(0, 40)), 12'd3, 12'($urandom_range(0, 4095))};

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // directed, reset limit: both alphabets, blanks, empty and partial texts, errors
    write_limit(b64d_pkg::LIMIT_RESET);
    push_string("TWFu");
    push_end();
    push_string("AZaz09-_+/");
    push_end();
    push_char(CH_SPACE);
    push_char("Q");
    push_char(CH_CR);
    push_char(CH_LF);
    push_string("Q=");
    push_char(CH_TAB);
    push_end();
    push_end();
    push_char("Q");
    push_end();
    push_string("TW");
    push_char(8'hFF);
    push_string("Fu");
    push_end();
    push_char(8'h00);
    push_end();
    wait_idle();

    // zero limit: first completed byte overflows, then an empty text
    write_limit(12'd0);
    push_string("QUJD");
    push_end();
    push_end();
    wait_idle();

    // overflow partway through a text
    write_limit(12'd2);
    push_string("QUJD");
    push_end();
    wait_idle();

    // random texts over a range of limits
    foreach (phase_limits[p]) begin
      write_limit(phase_limits[p]);
      if (phase_limits[p] == 12'd384) queue_random_text(520, 520, 1'b0);
      start = items_queued;
      while (items_queued - start < PHASE_ITEMS)
        queue_random_text(0, (phase_limits[p] == 12'd4095) ? 60 : 24, 1'b1);
      wait_idle();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS base64url_stream_decoder");
    end else begin
      $display("FAIL base64url_stream_decoder");
    end
    $finish;
  end

endmodule
